// File: hdl/thipe_pkg.sv
// ----------------------------------------------------------------------------
// thipe_pkg: shared types and constants of the tone peak extractor
// Widths, register indexes and the beat and configuration structures that
// travel between the configuration block, the window cells and the top level.
// ----------------------------------------------------------------------------
package thipe_pkg;

	localparam int FREQ_BITS = 40;
	localparam int PWR_W     = 17;
	localparam int NUM_WIN   = 10;
	localparam int NUM_OUT   = 5;

	// Targets reach 3*f in magnitude: two extra bits plus a sign bit.
	localparam int TGT_W  = FREQ_BITS + 3;
	// Line frequency minus target needs one more bit than the target.
	localparam int DIST_W = FREQ_BITS + 4;

	localparam int IN_BITS      = FREQ_BITS + PWR_W;
	localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS     = NUM_OUT * PWR_W;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_DATA_W = 64;
	localparam int ADDR_W     = 6;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_TONE_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_FREQ = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_FREQ = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FUND_TOL   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PROD_TOL   = 3'd4;

	localparam logic [1:0] TONES_NONE = 2'd0;
	localparam logic [1:0] TONES_ONE  = 2'd1;

	localparam logic [FREQ_BITS-1:0] TOL_RESET = FREQ_BITS'(1000000);

	typedef logic signed [PWR_W-1:0]  power_t;
	typedef logic signed [TGT_W-1:0]  target_t;
	typedef logic signed [DIST_W-1:0] dist_t;

	localparam power_t POWER_FLOOR = -17'sd51200;
	localparam power_t POWER_CEIL  = 17'sd25600;

	// One spectrum line as it moves down the cell row. The slots collect the
	// cell peaks of a last line, one slot shifted in per cell.
	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic [FREQ_BITS-1:0]     freq;
		power_t                   power;
		power_t [NUM_WIN-1:0]     slots;
	} beat_t;

	// Configuration and the window geometry derived from it.
	typedef struct packed {
		logic [1:0]               tone_count;
		target_t [NUM_WIN-1:0]    target;
		dist_t                    fund_tol;
		dist_t                    fund_ntol;
		dist_t                    prod_tol;
		dist_t                    prod_ntol;
	} cfg_t;

endpackage

// File: hdl/tone_harmonic_intermod_peak_extractor.sv
// ----------------------------------------------------------------------------
// tone_harmonic_intermod_peak_extractor: harmonic and IM peak detector
// Streams spectrum lines through ten window cells and reports fundamental,
// harmonic and intermodulation peak powers at the end of each spectrum.
// ----------------------------------------------------------------------------
// The block takes one spectrum line per clock cycle on the s_ stream and
// never needs a gap between lines. Each line passes through a row of ten
// window cells, one cell per cycle; cell i follows the peak power inside the
// window around one target frequency (f1, f2, 2f1, 2f2, 3f1, 3f2, 2f1-f2,
// 2f2-f1, 3f1-2f2, 3f2-2f1). A line is inside a window when its distance to
// the target is strictly below the tolerance (fundamental tolerance for f1
// and f2, product tolerance for all others). The beat marked by s_tlast
// closes the spectrum: its five-field result appears on m_tdata once it
// has passed the input register, the ten cells and the output register,
// and every window starts again from the -200 dBm floor for the next
// line. Lines without s_tlast give no output beat. The whole row advances
// together and stops only when a closing beat reaches its end while the
// previous result still waits on the m_ side; s_tready is low exactly then.
// Line power is clamped to -200 dBm .. +100 dBm before use. In single-tone
// mode only the f1 windows are reported and both IM fields hold the floor;
// with no tones every field holds the floor. The registers sit on an APB
// port at byte addresses 0, 8, 16, 24 and 32 and should only be written
// while no spectrum is in flight, at least eleven cycles after the last beat.
// ----------------------------------------------------------------------------
module tone_harmonic_intermod_peak_extractor (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [thipe_pkg::ADDR_W-1:0]      paddr,
	input  logic [thipe_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [thipe_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                              pready,
	// Spectrum line input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: line_frequency [39:0], line_power [56:40], zero fill above
	input  logic [thipe_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                              s_tlast,
	// Result output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: fund_pwr [16:0], harm2_pwr [33:17], harm3_pwr [50:34],
	// imd3_pwr [67:51], imd5_pwr [84:68], zero fill
	output logic [thipe_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import thipe_pkg::*;

	cfg_t   cfg;
	logic   adv;
	logic   row_result;
	logic   out_free;
	power_t in_power, sat_power;
	logic   line_valid_q;
	beat_t  line_s0;
	beat_t  chain [0:NUM_WIN];
	power_t win_peak [NUM_WIN];
	power_t res [NUM_OUT];
	logic   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	function automatic power_t pmax(input power_t a, input power_t b);
		return (a > b) ? a : b;
	endfunction

	assign pready = 1'b1;

	thipe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The row only has to wait when a closing beat is about to leave it and
	// the output register still holds a result nobody has taken.
	assign row_result = chain[NUM_WIN].valid && chain[NUM_WIN].last;
	assign out_free   = !m_valid_q || m_tready;
	assign adv        = out_free || !row_result;
	assign s_tready   = adv;

	// Input stage: clamp the power before it enters the row.
	always_comb begin
		in_power = $signed(s_tdata[FREQ_BITS +: PWR_W]);
		if (in_power < POWER_FLOOR) begin
			sat_power = POWER_FLOOR;
		end else if (in_power > POWER_CEIL) begin
			sat_power = POWER_CEIL;
		end else begin
			sat_power = in_power;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= 1'b0;
		end else if (adv) begin
			line_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			line_s0.valid <= s_tvalid;
			line_s0.last  <= s_tlast;
			line_s0.freq  <= s_tdata[FREQ_BITS-1:0];
			line_s0.power <= sat_power;
			line_s0.slots <= '0;
		end
	end

	always_comb begin
		chain[0]       = line_s0;
		chain[0].valid = line_valid_q;
	end

	for (genvar i = 0; i < NUM_WIN; i++) begin : g_cell
		thipe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.beat_in  (chain[i]),
			.target   (cfg.target[i]),
			.tol      ((i < 2) ? cfg.fund_tol : cfg.prod_tol),
			.ntol     ((i < 2) ? cfg.fund_ntol : cfg.prod_ntol),
			.beat_out (chain[i+1])
		);
		// Each cell shifts its peak into slot 0, so cell i ends up in the
		// slot counted from the far end.
		assign win_peak[i] = chain[NUM_WIN].slots[NUM_WIN-1-i];
	end

	// Pair the windows according to the tone mode.
	always_comb begin
		for (int k = 0; k < NUM_OUT; k++) begin
			res[k] = POWER_FLOOR;
		end
		unique case (cfg.tone_count)
			TONES_NONE: ;
			TONES_ONE: begin
				res[0] = win_peak[0];
				res[1] = win_peak[2];
				res[2] = win_peak[4];
			end
			default: begin
				for (int k = 0; k < NUM_OUT; k++) begin
					res[k] = pmax(win_peak[2*k], win_peak[2*k+1]);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= row_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && row_result) begin
			m_data_q <= OUT_TDATA_W'({res[4], res[3], res[2], res[1], res[0]});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: hdl/thipe_cfg.sv
// ----------------------------------------------------------------------------
// thipe_cfg: configuration registers and window targets
// Holds the register file behind the APB port and registers the ten target
// frequencies and the signed tolerance bounds together with each write.
// ----------------------------------------------------------------------------
module thipe_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [thipe_pkg::ADDR_W-1:0]     paddr,
	input  logic [thipe_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [thipe_pkg::CFG_DATA_W-1:0] prdata,
	output thipe_pkg::cfg_t                  cfg
);
	import thipe_pkg::*;

	logic [1:0]           tone_q, tone_d;
	logic [FREQ_BITS-1:0] f1_q, f1_d, f2_q, f2_d;
	logic [FREQ_BITS-1:0] ftol_q, ftol_d, ptol_q, ptol_d;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	target_t              e1, e2, t1x2, t2x2, t1x3, t2x3;
	cfg_t                 cfg_d, cfg_q;

	assign idx   = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
	assign wr_en = psel & penable & pwrite;

	always_comb begin
		tone_d = tone_q;
		f1_d   = f1_q;
		f2_d   = f2_q;
		ftol_d = ftol_q;
		ptol_d = ptol_q;
		if (wr_en) begin
			unique case (idx)
				REG_TONE_COUNT:  tone_d = pwdata[1:0];
				REG_FIRST_FREQ:  f1_d   = pwdata[FREQ_BITS-1:0];
				REG_SECOND_FREQ: f2_d   = pwdata[FREQ_BITS-1:0];
				REG_FUND_TOL:    ftol_d = pwdata[FREQ_BITS-1:0];
				REG_PROD_TOL:    ptol_d = pwdata[FREQ_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Targets come from the next register values so they change on the
	// same edge as the registers themselves.
	always_comb begin
		e1   = $signed({3'b000, f1_d});
		e2   = $signed({3'b000, f2_d});
		t1x2 = e1 + e1;
		t2x2 = e2 + e2;
		t1x3 = t1x2 + e1;
		t2x3 = t2x2 + e2;
		cfg_d.tone_count = tone_d;
		cfg_d.target[0]  = e1;
		cfg_d.target[1]  = e2;
		cfg_d.target[2]  = t1x2;
		cfg_d.target[3]  = t2x2;
		cfg_d.target[4]  = t1x3;
		cfg_d.target[5]  = t2x3;
		cfg_d.target[6]  = t1x2 - e2;
		cfg_d.target[7]  = t2x2 - e1;
		cfg_d.target[8]  = t1x3 - t2x2;
		cfg_d.target[9]  = t2x3 - t1x2;
		cfg_d.fund_tol   = $signed({4'b0000, ftol_d});
		cfg_d.fund_ntol  = -$signed({4'b0000, ftol_d});
		cfg_d.prod_tol   = $signed({4'b0000, ptol_d});
		cfg_d.prod_ntol  = -$signed({4'b0000, ptol_d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q <= TONES_NONE;
			f1_q   <= '0;
			f2_q   <= '0;
			ftol_q <= TOL_RESET;
			ptol_q <= TOL_RESET;
			cfg_q.tone_count <= TONES_NONE;
			cfg_q.target     <= '0;
			cfg_q.fund_tol   <= $signed({4'b0000, TOL_RESET});
			cfg_q.fund_ntol  <= -$signed({4'b0000, TOL_RESET});
			cfg_q.prod_tol   <= $signed({4'b0000, TOL_RESET});
			cfg_q.prod_ntol  <= -$signed({4'b0000, TOL_RESET});
		end else begin
			tone_q <= tone_d;
			f1_q   <= f1_d;
			f2_q   <= f2_d;
			ftol_q <= ftol_d;
			ptol_q <= ptol_d;
			cfg_q  <= cfg_d;
		end
	end

	assign cfg = cfg_q;

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TONE_COUNT:  prdata = CFG_DATA_W'(tone_q);
			REG_FIRST_FREQ:  prdata = CFG_DATA_W'(f1_q);
			REG_SECOND_FREQ: prdata = CFG_DATA_W'(f2_q);
			REG_FUND_TOL:    prdata = CFG_DATA_W'(ftol_q);
			REG_PROD_TOL:    prdata = CFG_DATA_W'(ptol_q);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: hdl/thipe_cell.sv
// ----------------------------------------------------------------------------
// thipe_cell: one frequency window of the cell row
// Tracks the peak power of lines inside its window and passes each line on
// to the next cell. On a last line it shifts its final peak into the slots.
// ----------------------------------------------------------------------------
module thipe_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  thipe_pkg::beat_t  beat_in,
	input  thipe_pkg::target_t target,
	input  thipe_pkg::dist_t  tol,
	input  thipe_pkg::dist_t  ntol,
	output thipe_pkg::beat_t  beat_out
);
	import thipe_pkg::*;

	power_t peak_q, peak_new;
	dist_t  diff;
	logic   hit;
	logic   valid_q;
	beat_t  beat_nx;
	beat_t  beat_s1;

	// The window test is -tol < diff < tol, which needs no absolute value.
	always_comb begin
		diff     = $signed({{(DIST_W-FREQ_BITS){1'b0}}, beat_in.freq}) - dist_t'(target);
		hit      = (diff < tol) && (diff > ntol) && (beat_in.power > peak_q);
		peak_new = hit ? beat_in.power : peak_q;
		beat_nx       = beat_in;
		beat_nx.slots = {beat_in.slots[NUM_WIN-2:0], peak_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= POWER_FLOOR;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= beat_in.valid;
			if (beat_in.valid) begin
				peak_q <= beat_in.last ? POWER_FLOOR : peak_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_s1 <= beat_nx;
		end
	end

	always_comb begin
		beat_out       = beat_s1;
		beat_out.valid = valid_q;
	end

endmodule

// File: hdl/thipe_checker.sv
// ----------------------------------------------------------------------------
// thipe_checker: port-level checks of the tone peak extractor
// Watches the top-level ports and flags stalls that lose data, a broken
// ready path, results out of range and tone-mode fields off the floor.
// ----------------------------------------------------------------------------
module thipe_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [thipe_pkg::ADDR_W-1:0]      paddr,
	input logic [thipe_pkg::CFG_DATA_W-1:0]  pwdata,
	input logic                              pready,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [thipe_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import thipe_pkg::*;

	logic [1:0] tone_q;

	function automatic logic in_range(input logic [PWR_W-1:0] v);
		return ($signed(v) >= POWER_FLOOR) && ($signed(v) <= POWER_CEIL);
	endfunction

	// Shadow of the tone mode register as seen on the APB port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q <= TONES_NONE;
		end else if (psel && penable && pwrite && pready &&
		             paddr[ADDR_W-1:ADDR_W-REG_IDX_W] == REG_TONE_COUNT) begin
			tone_q <= pwdata[1:0];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input held off although the output side is free");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> in_range(m_tdata[16:0]) && in_range(m_tdata[33:17]) &&
		             in_range(m_tdata[50:34]) && in_range(m_tdata[67:51]) &&
		             in_range(m_tdata[84:68]))
		else $error("result power outside the field range");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && tone_q == TONES_ONE |->
		$signed(m_tdata[67:51]) == POWER_FLOOR && $signed(m_tdata[84:68]) == POWER_FLOOR)
		else $error("intermod field off the floor in single-tone mode");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && tone_q == TONES_NONE |->
		$signed(m_tdata[16:0]) == POWER_FLOOR && $signed(m_tdata[33:17]) == POWER_FLOOR)
		else $error("power reported with no tones configured");

endmodule

bind tone_harmonic_intermod_peak_extractor thipe_checker u_thipe_checker (.*);

// File: dv/tone_harmonic_intermod_peak_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_harmonic_intermod_peak_extractor_tb: self-checking bench of the peak extractor
// Streams spectra into the block and keeps its own copy of the ten window peaks
// for each spectrum. Every output beat is checked field by field against the
// predicted peak set. The run covers several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tone_harmonic_intermod_peak_extractor_tb;
	import thipe_pkg::*;

	localparam int    CYCLE_LIMIT   = 400000;
	localparam int    SETTLE_CYCLES = 24;
	localparam int    HOLD_CYCLES   = 300;
	localparam int    MAX_PRINTS    = 40;
	localparam longint FREQ_MAX     = (longint'(1) << FREQ_BITS) - 1;

	// A register index that decodes to nothing; writes there must be ignored.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;

	// Phase flavors: plain streaming, a long receiver hold-off, a mid-phase drain.
	localparam int PHASE_PLAIN = 0;
	localparam int PHASE_HOLD  = 1;
	localparam int PHASE_PAUSE = 2;

	typedef struct {
		logic [FREQ_BITS-1:0] freq;
		power_t               power;
		logic                 is_last;
	} line_t;

	// Five reported powers, fundamental in element 0 as on m_tdata.
	typedef power_t [NUM_OUT-1:0] peak_set_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [CFG_DATA_W-1:0]  pwdata;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	tone_harmonic_intermod_peak_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Mirror of the register file, updated when an APB write completes.
	logic [1:0]           cfg_tones;
	logic [FREQ_BITS-1:0] cfg_f1;
	logic [FREQ_BITS-1:0] cfg_f2;
	logic [FREQ_BITS-1:0] cfg_ftol;
	logic [FREQ_BITS-1:0] cfg_ptol;

	// Predicted running maxima, one per target window.
	power_t    win_peak [NUM_WIN];
	line_t     line_q [$];
	peak_set_t peak_report_q [$];

	int   err_cnt        = 0;
	int   cycle_cnt      = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_seq       = 0;
	int   hold_seen      = 0;
	int   hold_left      = 0;
	logic line_taken     = 1'b0;
	line_t drv_line;

	task automatic report_mismatch(string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	function automatic void clear_window_peaks();
		for (int i = 0; i < NUM_WIN; i++)
			win_peak[i] = POWER_FLOOR;
	endfunction

	// Target frequency of window k, formed in 64 bits so nothing wraps.
	function automatic longint window_target(int k);
		longint a;
		longint b;
		a = longint'(cfg_f1);
		b = longint'(cfg_f2);
		case (k)
			0: return a;
			1: return b;
			2: return 2 * a;
			3: return 2 * b;
			4: return 3 * a;
			5: return 3 * b;
			6: return 2 * a - b;
			7: return 2 * b - a;
			8: return 3 * a - 2 * b;
			default: return 3 * b - 2 * a;
		endcase
	endfunction

	// The two fundamental windows use their own half-width.
	function automatic longint window_tol(int k);
		return (k < 2) ? longint'(cfg_ftol) : longint'(cfg_ptol);
	endfunction

	// Folds one accepted line into the window peaks; a closing line also
	// queues the peak set the block is expected to report.
	function automatic void fold_line(logic [FREQ_BITS-1:0] lf, power_t p_in, logic closing);
		power_t    p;
		longint    d;
		peak_set_t r;
		p = p_in;
		if (p < POWER_FLOOR)
			p = POWER_FLOOR;
		if (p > POWER_CEIL)
			p = POWER_CEIL;
		for (int i = 0; i < NUM_WIN; i++) begin
			d = longint'(lf) - window_target(i);
			if (d < 0)
				d = -d;
			if (d < window_tol(i) && p > win_peak[i])
				win_peak[i] = p;
		end
		if (!closing)
			return;
		for (int i = 0; i < NUM_OUT; i++)
			r[i] = POWER_FLOOR;
		// Windows are laid out in pairs, so output i is the pair 2i and 2i+1.
		if (cfg_tones == TONES_ONE) begin
			for (int i = 0; i < 3; i++)
				r[i] = win_peak[2 * i];
		end else if (cfg_tones != TONES_NONE) begin
			for (int i = 0; i < NUM_OUT; i++)
				r[i] = (win_peak[2 * i] > win_peak[2 * i + 1]) ? win_peak[2 * i]
					: win_peak[2 * i + 1];
		end
		peak_report_q = {peak_report_q, r};
		clear_window_peaks();
	endfunction

	task automatic check_peak_beat();
		peak_set_t want;
		power_t    got;
		string     fname [NUM_OUT];
		fname = '{"fund_pwr", "harm2_pwr", "harm3_pwr", "imd3_pwr", "imd5_pwr"};
		if (peak_report_q.size() == 0) begin
			report_mismatch($sformatf("result beat with no spectrum pending, tdata %h", m_tdata));
			return;
		end
		want = peak_report_q.pop_front();
		for (int i = 0; i < NUM_OUT; i++) begin
			got = m_tdata[i * PWR_W +: PWR_W];
			if (got !== want[i])
				report_mismatch($sformatf("%s got %0d expected %0d", fname[i], got, want[i]));
		end
	endtask

	// Input handshake and result checking, both sampled at the rising edge.
	always @(posedge clk) begin
		line_taken = arst_n && s_tvalid && s_tready;
		if (line_taken)
			fold_line(s_tdata[FREQ_BITS-1:0], s_tdata[FREQ_BITS +: PWR_W], s_tlast);
		if (arst_n && m_tvalid && m_tready)
			check_peak_beat();
	end

	// Line driver: presents the next queued line once the previous beat went
	// through, or idles at the current sender idle rate.
	always @(negedge clk) begin
		if (!s_tvalid || line_taken) begin
			if (arst_n && line_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_line = line_q.pop_front();
				s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, drv_line.power, drv_line.freq};
				s_tlast  <= drv_line.is_last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result sink. A bump of hold_seq starts a long hold-off counted here.
	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [FREQ_BITS-1:0] rand_freq();
		return {8'($urandom_range(0, 255)), 32'($urandom)};
	endfunction

	// Register data with the unused upper bits sometimes filled with junk;
	// the block must mask them off.
	function automatic logic [CFG_DATA_W-1:0] pad_reg(logic [CFG_DATA_W-1:0] v, int w);
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] junk;
		mask = (64'd1 << w) - 64'd1;
		junk = {$urandom, $urandom};
		if ($urandom_range(0, 1) == 0)
			return v & mask;
		return (junk & ~mask) | (v & mask);
	endfunction

	// Powers lean toward the legal range, with the clamp edges and the
	// out-of-range codes showing up regularly.
	function automatic power_t pick_power();
		case ($urandom_range(0, 19))
			0: return power_t'(17'h10000);
			1: return power_t'(17'h0FFFF);
			2: return POWER_FLOOR;
			3: return POWER_CEIL;
			4: return POWER_FLOOR - 17'sd1;
			5: return POWER_CEIL + 17'sd1;
			6, 7: return power_t'($urandom);
			default: return power_t'(int'($urandom_range(0, 76800)) - 51200);
		endcase
	endfunction

	// A line frequency aimed at one of the windows, often right on its edge.
	function automatic logic [FREQ_BITS-1:0] near_window_freq();
		int               k;
		longint           tol;
		longint           span;
		longint           off;
		longint           lf;
		longint unsigned  r;
		k   = $urandom_range(0, NUM_WIN - 1);
		tol = window_tol(k);
		case ($urandom_range(0, 5))
			0: off = tol - 1;
			1: off = tol;
			2: off = 1 - tol;
			3: off = -tol;
			4: off = 0;
			default: begin
				span = tol + tol / 4 + 2;
				r    = {$urandom, $urandom};
				off  = longint'(r % longint'(2 * span + 1)) - span;
			end
		endcase
		lf = window_target(k) + off;
		if (lf < 0)
			lf = 0;
		if (lf > FREQ_MAX)
			lf = FREQ_MAX;
		return lf[FREQ_BITS-1:0];
	endfunction

	task automatic push_line(logic [FREQ_BITS-1:0] f, power_t p, logic closing);
		line_t ln;
		ln.freq    = f;
		ln.power   = p;
		ln.is_last = closing;
		line_q = {line_q, ln};
	endtask

	// One spectrum of n lines; a few lines land anywhere in the band.
	task automatic push_spectrum(int n);
		for (int i = 0; i < n; i++)
			push_line(($urandom_range(0, 99) < 15) ? rand_freq() : near_window_freq(),
				pick_power(), i == n - 1);
	endtask

	// Blocks until every queued line went in and every result came out,
	// then lets the pipeline run empty.
	task automatic wait_results(int settle);
		@(posedge clk);
		while (line_q.size() != 0 || s_tvalid || peak_report_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_TONE_COUNT:  cfg_tones = data[1:0];
			REG_FIRST_FREQ:  cfg_f1    = data[FREQ_BITS-1:0];
			REG_SECOND_FREQ: cfg_f2    = data[FREQ_BITS-1:0];
			REG_FUND_TOL:    cfg_ftol  = data[FREQ_BITS-1:0];
			REG_PROD_TOL:    cfg_ptol  = data[FREQ_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Reprograms all five registers once the block has gone quiet.
	task automatic set_config(logic [1:0] tones, logic [FREQ_BITS-1:0] f1,
		logic [FREQ_BITS-1:0] f2, logic [FREQ_BITS-1:0] ftol, logic [FREQ_BITS-1:0] ptol);
		wait_results(SETTLE_CYCLES);
		reg_write(REG_TONE_COUNT, pad_reg(64'(tones), 2));
		reg_write(REG_FIRST_FREQ, pad_reg(64'(f1), FREQ_BITS));
		reg_write(REG_SECOND_FREQ, pad_reg(64'(f2), FREQ_BITS));
		reg_write(REG_FUND_TOL, pad_reg(64'(ftol), FREQ_BITS));
		reg_write(REG_PROD_TOL, pad_reg(64'(ptol), FREQ_BITS));
		if ($urandom_range(0, 2) == 0)
			reg_write(REG_SPARE, {$urandom, $urandom});
	endtask

	task automatic run_phase(logic [1:0] tones, logic [FREQ_BITS-1:0] f1,
		logic [FREQ_BITS-1:0] f2, logic [FREQ_BITS-1:0] ftol, logic [FREQ_BITS-1:0] ptol,
		int n, int spct, int rpct, int flavor);
		int count;
		int len;
		bit done_extra;
		count      = 0;
		done_extra = 0;
		set_config(tones, f1, f2, ftol, ptol);
		send_idle_pct  = spct;
		recv_stall_pct = rpct;
		while (count < n) begin
			// Short spectra under a hold-off pile results up inside the block.
			len = (flavor == PHASE_HOLD) ? $urandom_range(1, 4) : $urandom_range(1, 14);
			push_spectrum(len);
			count += len;
			if (!done_extra && flavor == PHASE_HOLD && count >= 8) begin
				hold_seq++;
				done_extra = 1;
			end
			if (!done_extra && flavor == PHASE_PAUSE && count >= n / 2) begin
				wait_results(0);
				done_extra = 1;
			end
		end
	endtask

	initial begin
		logic [FREQ_BITS-1:0] fa;
		logic [FREQ_BITS-1:0] fb;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		arst_n    = 1'b0;
		cfg_tones = TONES_NONE;
		cfg_f1    = '0;
		cfg_f2    = '0;
		cfg_ftol  = TOL_RESET;
		cfg_ptol  = TOL_RESET;
		clear_window_peaks();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: no tones, so even a line inside the f1 window
		// reports the floor everywhere.
		push_line(40'd1000, POWER_CEIL, 1'b1);

		// Two tones 1 MHz apart with narrow windows; lines sit on the window
		// edges and carry the power extremes and the clamp cases.
		set_config(2'd2, 40'd1_000_000_000, 40'd1_001_000_000, 40'd1000, 40'd500);
		push_line(40'd1_000_000_000, POWER_CEIL, 1'b0);
		push_line(40'd1_001_000_999, POWER_CEIL + 17'sd1, 1'b0);
		push_line(40'd1_001_001_000, 17'sd100, 1'b0);
		push_line(40'd999_000_000, POWER_FLOOR - 17'sd1, 1'b0);
		push_line(40'd1_001_999_501, 17'sd0, 1'b0);
		push_line(40'd998_000_000, power_t'(17'h10000), 1'b0);
		push_line(40'd1_003_000_499, power_t'(17'h0FFFF), 1'b0);
		push_line(40'd2_000_000_000, -17'sd2560, 1'b0);
		push_line(40'd2_002_000_000, -17'sd1280, 1'b0);
		push_line(40'd3_000_000_000, 17'sd256, 1'b0);
		push_line(40'd3_003_000_000, 17'sd512, 1'b0);
		push_line(40'd0, -17'sd100, 1'b0);
		push_line(FREQ_BITS'(FREQ_MAX), -17'sd1, 1'b0);
		push_line(40'd3_000_000_500, 17'sd5000, 1'b1);
		// A lone closing line: all windows start from the floor again.
		push_line(40'd0, POWER_FLOOR, 1'b1);

		// Single tone ignores the f2 windows and reports floor for IM.
		set_config(2'd1, 40'd1_000_000_000, 40'd1_001_000_000, 40'd1000, 40'd500);
		push_line(40'd1_000_000_000, 17'sd1000, 1'b0);
		push_line(40'd2_000_000_499, 17'sd2000, 1'b0);
		push_line(40'd1_001_000_000, 17'sd3000, 1'b1);
		set_config(2'd0, 40'd1_000_000_000, 40'd1_001_000_000, 40'd1000, 40'd500);
		push_line(40'd1_000_000_000, 17'sd1000, 1'b1);
		// Tone count three behaves as two tones.
		set_config(2'd3, 40'd1_000_000_000, 40'd1_001_000_000, 40'd1000, 40'd500);
		push_line(40'd999_000_001, 17'sd700, 1'b0);
		push_line(40'd1_001_000_000, 17'sd800, 1'b1);
		// Negative IM targets that still reach lines near zero.
		set_config(2'd2, 40'd100, 40'd1000, 40'd10, 40'd1000);
		push_line(40'd0, 17'sd1200, 1'b0);
		push_line(40'd199, 17'sd1300, 1'b1);

		// Random spectra across the register space and the idle patterns.
		fa = 40'($urandom_range(100_000_000, 2_000_000_000));
		fb = fa + 40'($urandom_range(100_000, 50_000_000));
		run_phase(2'd2, fa, fb, 40'd1_000_000, 40'd1_000_000, 105, 0, 0, PHASE_PLAIN);
		fa = 40'($urandom_range(100_000_000, 2_000_000_000));
		fb = fa + 40'($urandom_range(100_000, 50_000_000));
		run_phase(2'd1, fa, fb, 40'd2_000_000, 40'd500_000, 105, 50, 0, PHASE_PLAIN);
		run_phase(2'd3, fb, fa, 40'd700_000, 40'd3_000_000, 105, 0, 50, PHASE_PLAIN);
		run_phase(2'd0, fa, fb, 40'd1_000_000, 40'd1_000_000, 105, 32, 32, PHASE_PLAIN);
		// Zero-width windows: nothing is ever inside.
		run_phase(2'd2, fa, fb, 40'd0, 40'd0, 105, 0, 0, PHASE_PLAIN);
		// Widest windows with a tiny f1, so several targets go negative.
		run_phase(2'd2, 40'($urandom_range(0, 1000)), rand_freq(), FREQ_BITS'(FREQ_MAX),
			FREQ_BITS'(FREQ_MAX), 105, 50, 0, PHASE_PLAIN);
		// Top of the band: harmonics far above the 40-bit range.
		run_phase(2'd2, FREQ_BITS'(FREQ_MAX), FREQ_BITS'(FREQ_MAX), rand_freq(), rand_freq(),
			105, 0, 50, PHASE_PLAIN);
		run_phase(2'd2, 40'd0, 40'd0, 40'($urandom_range(1, 5000)),
			40'($urandom_range(1, 5000)), 105, 32, 32, PHASE_PLAIN);
		fa = 40'($urandom_range(100_000_000, 2_000_000_000));
		fb = fa + 40'($urandom_range(100_000, 50_000_000));
		run_phase(2'd2, fa, fb, 40'd1_000_000, 40'd1_000_000, 150, 0, 0, PHASE_HOLD);
		fa = 40'($urandom_range(100_000_000, 2_000_000_000));
		fb = fa - 40'($urandom_range(100_000, 50_000_000));
		run_phase(2'd2, fa, fb, 40'($urandom_range(1, 2_000_000)),
			40'($urandom_range(1, 2_000_000)), 105, 0, 50, PHASE_PAUSE);
		run_phase(2'd1, rand_freq(), rand_freq(), rand_freq(), rand_freq(), 105, 32, 32,
			PHASE_PLAIN);
		fa = {2'b00, 38'({$urandom_range(0, 63), $urandom})};
		fb = {2'b00, 38'({$urandom_range(0, 63), $urandom})};
		run_phase(2'd2, fa, fb, 40'($urandom_range(1, 1 << 30)), 40'($urandom_range(1, 1 << 30)),
			105, 50, 50, PHASE_PLAIN);

		wait_results(SETTLE_CYCLES);
		if (peak_report_q.size() != 0)
			report_mismatch($sformatf("%0d spectra never reported", peak_report_q.size()));
		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
